// ===== hw/rtl/throughput_core_allocator_defines.svh =====
// ------------------------------------------------------------------------
// Throughput core allocator: assertion macros
// Shared concurrent assertion forms for the allocator's RTL modules.
// ------------------------------------------------------------------------
`ifndef THROUGHPUT_CORE_ALLOCATOR_DEFINES_SVH
`define THROUGHPUT_CORE_ALLOCATOR_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define THR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, including edges while reset is held.
`define THR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/thr_pkg.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator package
// Field widths, register codes, reset values and shared types.
// ------------------------------------------------------------------------
`default_nettype none

package thr_pkg;

    // Field widths of the stream and configuration payloads.
    localparam int SCALE_W    = 16;
    localparam int TOL_W      = 16;
    localparam int CORES_W    = 13;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    // Step counter width of the serial divider.
    localparam int DIV_STEP_W = $clog2(CORES_W + 1);

    // Register reset values.
    localparam logic [CORES_W-1:0] TOTAL_CORES_RST = 13'd16;
    localparam logic [TOL_W-1:0]   TIE_TOL_RST     = 16'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_CORES = 2'd0,
        CFG_TIE_TOL     = 2'd1
    } cfg_index_t;

    // Back-end walk states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DIV  = 2'd2
    } back_state_t;

    // Round summary handed from the front end to the back end.
    typedef struct packed {
        logic [CNT_W-1:0] proc_cnt;
        logic [CNT_W-1:0] best_cnt;
    } round_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/thr_front.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator front end
// Accepts scaling factors, tracks the running maximum and best-process mask,
// and pushes a round summary into the queue on the closing request.
// ------------------------------------------------------------------------
`default_nettype none

module thr_front
    import thr_pkg::*;
#(
    parameter int MAX_PROCESSES = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [SCALE_W-1:0]       s_tdata,    // [15:0] scaling
    input  wire logic                     s_tlast,
    input  wire logic [TOL_W-1:0]         tie_tolerance,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output logic [MAX_PROCESSES-1:0]      q_mask,
    output round_info_t                   q_info
);

    logic [SCALE_W-1:0]       max_reg,  max_next;
    logic [MAX_PROCESSES-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]         cnt_reg,  cnt_next;
    logic [CNT_W-1:0]         best_reg, best_next;

    logic                     accept;
    logic                     first_item;
    logic                     greater;
    logic                     tie;
    logic                     closing;
    logic [SCALE_W-1:0]       diff;
    logic [MAX_PROCESSES-1:0] bit_sel;

    // A request is taken whenever the queue can hold a round summary.
    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // Classify the incoming scaling factor against the running maximum.
    assign first_item = (cnt_reg == '0);
    assign greater    = (s_tdata > max_reg);
    assign diff       = max_reg - s_tdata;
    assign tie        = !greater && (diff <= tie_tolerance);

    // Mask bit of the current process.
    always_comb
    begin
        for (int j = 0; j < MAX_PROCESSES; j++)
        begin
            bit_sel[j] = (cnt_reg == CNT_W'(j));
        end
    end

    // Next maximum, mask and counts.
    always_comb
    begin
        max_next  = max_reg;
        mask_next = mask_reg;
        best_next = best_reg;
        if (first_item || greater)
        begin
            max_next  = s_tdata;
            mask_next = bit_sel;
            best_next = CNT_W'(1);
        end
        else if (tie)
        begin
            mask_next = mask_reg | bit_sel;
            best_next = best_reg + CNT_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(1);
    end

    // A round closes on the last flag or when the table is full.
    assign closing = s_tlast || (cnt_next == CNT_W'(MAX_PROCESSES));

    assign q_valid         = accept && closing;
    assign q_mask          = mask_next;
    assign q_info.proc_cnt = cnt_next;
    assign q_info.best_cnt = best_next;

    // Round state registers; cleared once the summary is queued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            mask_reg <= '0;
            cnt_reg  <= '0;
            best_reg <= '0;
        end
        else if (accept)
        begin
            if (closing)
            begin
                max_reg  <= '0;
                mask_reg <= '0;
                cnt_reg  <= '0;
                best_reg <= '0;
            end
            else
            begin
                max_reg  <= max_next;
                mask_reg <= mask_next;
                cnt_reg  <= cnt_next;
                best_reg <= best_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/thr_queue.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator round queue
// Two-entry queue of round summaries between the front and back ends.
// ------------------------------------------------------------------------
`default_nettype none

module thr_queue #(
    parameter int DATA_W = 78
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Storage entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/thr_div.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator divider
// Restoring serial divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
`default_nettype none

module thr_div
    import thr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [CORES_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]   divisor,
    output logic                    busy,
    output logic [CORES_W-1:0]      quotient
);

    logic                  busy_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]      div_reg;
    logic [CNT_W-1:0]      rem_reg,  rem_next;
    logic [CORES_W-1:0]    quo_reg,  quo_next;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        trial_sub;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial     = {rem_reg, quo_reg[CORES_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    always_comb
    begin
        rem_next = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_next = {quo_reg[CORES_W-2:0], fits};
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // Control: step count and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(CORES_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/thr_back.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator back end
// Walks a queued round in process order and emits one allocation per
// process through an output register.
// ------------------------------------------------------------------------
`default_nettype none

module thr_back
    import thr_pkg::*;
#(
    parameter int MAX_PROCESSES = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [CORES_W-1:0]       total_cores,
    input  wire logic                     q_valid,
    output logic                          q_ready,
    input  wire logic [MAX_PROCESSES-1:0] q_mask,
    input  wire round_info_t              q_info,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,    // [5:0] process_index,
                                                      // [18:6] alloc_cores
    output logic                          m_tlast
);

    back_state_t              state_reg, state_next;
    logic [MAX_PROCESSES-1:0] mask_reg,  mask_next;
    logic [CNT_W-1:0]         idx_reg,   idx_next;
    logic [CNT_W-1:0]         n_reg,     n_next;
    logic [CNT_W-1:0]         left_reg,  left_next;
    logic [CORES_W-1:0]       cores_reg, cores_next;

    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [CORES_W-1:0]       out_alloc_reg;
    logic                     out_last_reg;

    logic                     out_load;
    logic [CORES_W-1:0]       out_alloc_val;
    logic                     out_free;
    logic                     is_last;
    logic [CNT_W-1:0]         non_best;
    logic [CORES_W-1:0]       non_best_ext;
    logic [CORES_W-1:0]       spare_cores;
    logic                     div_start;
    logic                     div_busy;
    logic [CORES_W-1:0]       div_quo;
    logic [CORES_W-1:0]       share;

    // Cores left for the best processes, clamped at zero.
    assign non_best     = q_info.proc_cnt - q_info.best_cnt;
    assign non_best_ext = CORES_W'(non_best);
    assign spare_cores  = (total_cores > non_best_ext) ? (total_cores - non_best_ext) : '0;

    assign out_free = !out_valid_reg || m_tready;
    assign is_last  = ((idx_reg + CNT_W'(1)) == n_reg);
    assign share    = (left_reg == '0) ? '0 : div_quo;

    thr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cores_reg),
        .divisor  (left_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Walk sequencer: next state and outputs.
    always_comb
    begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        left_next     = left_reg;
        cores_next    = cores_reg;
        q_ready       = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        out_alloc_val = '0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    mask_next  = q_mask;
                    n_next     = q_info.proc_cnt;
                    left_next  = q_info.best_cnt;
                    cores_next = spare_cores;
                    idx_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (mask_reg[0])
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    // A non-best process always gets a single core.
                    out_load      = 1'b1;
                    out_alloc_val = CORES_W'(1);
                    mask_next     = mask_reg >> 1;
                    idx_next      = idx_reg + CNT_W'(1);
                    state_next    = is_last ? ST_IDLE : ST_WALK;
                end
            end
            ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_load      = 1'b1;
                    out_alloc_val = share;
                    cores_next    = cores_reg - share;
                    left_next     = left_reg - CNT_W'(1);
                    mask_next     = mask_reg >> 1;
                    idx_next      = idx_reg + CNT_W'(1);
                    state_next    = is_last ? ST_IDLE : ST_WALK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk datapath and output payload.
    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        left_reg  <= left_next;
        cores_reg <= cores_next;
        if (out_load)
        begin
            out_idx_reg   <= idx_reg[IDX_W-1:0];
            out_alloc_reg <= out_alloc_val;
            out_last_reg  <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CORES_W - IDX_W)'(0), out_alloc_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // Checks.
`include "throughput_core_allocator_defines.svh"

    `THR_ASSERT_RST(a_reset_idle, !rst_n |=> (state_reg == ST_IDLE && !out_valid_reg), "back end not idle in reset")
    `THR_ASSERT(a_div_share, (state_reg == ST_DIV) |-> (left_reg != '0), "division with no best process left")
    `THR_ASSERT(a_div_owner, div_busy |-> (state_reg == ST_DIV), "divider running outside divide state")
    `THR_ASSERT(a_last_ends, (out_load && is_last) |=> (state_reg == ST_IDLE), "walk continued past last process")
    `THR_ASSERT(a_cores_down, (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |-> (cores_reg <= $past(cores_reg)), "remaining cores grew during a walk")

endmodule

`default_nettype wire

// ===== hw/rtl/throughput_core_allocator.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator
// Usage:
//   s_* channel: one request per process, tdata[15:0] is its scaling factor
//   (unsigned Q4.12), tlast marks the final process of a round. A round also
//   closes on its MAX_PROCESSES-th request.
//   m_* channel: after a round closes, one result per process in index order:
//   tdata[5:0] process index, tdata[18:6] granted cores, tlast on the last.
//   cfg_* channel: index 0 writes total_cores, index 1 writes tie_tolerance;
//   always ready, write only while the block is idle.
//   Loading takes one request per cycle while the round queue has room. The
//   closing request is pushed into the round queue, the back end takes the
//   round and walks it, and each result passes through the output register.
//   A best process waits for the serial divider in the back end; a non-best one does not.
//   A two-entry round queue lets the next round load while one is emitted;
//   s_tready drops only when both entries are taken.
//   Reset clears all round state and restores total_cores = 16 and
//   tie_tolerance = 4. When m_tready is low the output register holds its
//   result and the walk waits.
// ------------------------------------------------------------------------
`default_nettype none

module throughput_core_allocator
    import thr_pkg::*;
#(
    parameter int MAX_PROCESSES = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,    // [15:0] scaling
    input  wire logic                  s_tlast,    // last_process
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,    // [5:0] process_index,
                                                   // [18:6] alloc_cores
    output logic                       m_tlast,    // last_alloc
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int Q_W = MAX_PROCESSES + $bits(round_info_t);

    logic [CORES_W-1:0]       total_cores_reg;
    logic [TOL_W-1:0]         tie_tol_reg;

    logic                     fq_valid;
    logic                     fq_ready;
    logic [MAX_PROCESSES-1:0] fq_mask;
    round_info_t              fq_info;
    logic                     qb_valid;
    logic                     qb_ready;
    logic [Q_W-1:0]           qb_data;
    logic [MAX_PROCESSES-1:0] qb_mask;
    round_info_t              qb_info;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_cores_reg <= TOTAL_CORES_RST;
            tie_tol_reg     <= TIE_TOL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TOTAL_CORES: total_cores_reg <= cfg_data[CORES_W-1:0];
                CFG_TIE_TOL:     tie_tol_reg     <= cfg_data[TOL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Front end: load and classify processes.
    thr_front #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .tie_tolerance (tie_tol_reg),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_mask        (fq_mask),
        .q_info        (fq_info)
    );

    // Round queue between the two ends.
    thr_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_mask, fq_info}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    assign qb_mask = qb_data[Q_W-1:$bits(round_info_t)];
    assign qb_info = qb_data[$bits(round_info_t)-1:0];

    // Back end: walk and emit allocations.
    thr_back #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .total_cores (total_cores_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_mask      (qb_mask),
        .q_info      (qb_info),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sim/throughput_core_allocator_tb.sv =====
// ------------------------------------------------------------------------
// Throughput core allocator testbench
// Streams rounds of scaling factors into the allocator and checks every
// per-process core grant against a cycle-free model of the allocation rule,
// under random idle bursts on both stream sides, a long output stall that
// backs up the input, and several settings of the two registers.
// ------------------------------------------------------------------------
`default_nettype none

module throughput_core_allocator_tb;
    import thr_pkg::*;

    localparam int MAX_PROC    = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // One scaling request as queued for the driver.
    typedef struct {
        logic [SCALE_W-1:0] scaling;
        logic               last;
    } scale_req_t;

    // One expected core grant.
    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [CORES_W-1:0] cores;
        logic               last;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   m_tlast;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and expectation stores.
    scale_req_t scale_pending[$];
    grant_t     grants_expected[$];
    scale_req_t drv_req;
    grant_t     got_grant;
    grant_t     want_grant;

    // Shadow copy of the registers and the round state.
    logic [CORES_W-1:0] mdl_total = TOTAL_CORES_RST;
    logic [TOL_W-1:0]   mdl_tol = TIE_TOL_RST;
    logic [SCALE_W-1:0] mdl_max = '0;
    logic [63:0]        mdl_mask = '0;
    logic [CNT_W-1:0]   mdl_procs = '0;
    logic [CNT_W-1:0]   mdl_best = '0;

    // Bookkeeping.
    int  items_queued = 0;
    int  items_accepted = 0;
    int  grants_checked = 0;
    int  rounds_closed = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  hold_armed = 1'b0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;

    throughput_core_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [15:0] scaling
        .s_tlast   (s_tlast),      // last_process
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [5:0] process_index, [18:6] alloc_cores
        .m_tlast   (m_tlast),      // last_alloc
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Folds one scaling request into the round and, when the round closes,
    // queues one grant per process in index order.
    task automatic predict_allocation(input logic [SCALE_W-1:0] scaling,
                                      input logic closing);
        logic [IDX_W-1:0] slot;
        int n;
        int non_best;
        int remain;
        int left;
        int share;
        grant_t g;
        slot = mdl_procs[IDX_W-1:0];
        if (mdl_procs == 0 || scaling > mdl_max)
        begin
            mdl_max  = scaling;
            mdl_mask = 64'd1 << slot;
            mdl_best = CNT_W'(1);
        end
        else if (mdl_max - scaling <= mdl_tol)
        begin
            mdl_mask[slot] = 1'b1;
            mdl_best = mdl_best + 1'b1;
        end
        mdl_procs = mdl_procs + 1'b1;
        if (!closing && mdl_procs < MAX_PROC)
            return;

        // Non-best processes get one core; the best ones split the rest.
        n        = int'(mdl_procs);
        non_best = n - int'(mdl_best);
        remain   = (int'(mdl_total) > non_best) ? (int'(mdl_total) - non_best) : 0;
        left     = int'(mdl_best);
        for (int i = 0; i < n; i++)
        begin
            if (mdl_mask[i])
            begin
                share  = (left != 0) ? remain / left : 0;
                remain = remain - share;
                if (left != 0)
                    left = left - 1;
                g.cores = share[CORES_W-1:0];
            end
            else
                g.cores = CORES_W'(1);
            g.index = i[IDX_W-1:0];
            g.last  = (i + 1 == n);
            grants_expected = {grants_expected, g};
        end
        rounds_closed = rounds_closed + 1;
        mdl_max   = '0;
        mdl_mask  = '0;
        mdl_procs = '0;
        mdl_best  = '0;
    endtask

    task automatic push_item(input logic [SCALE_W-1:0] scaling, input logic last);
        scale_req_t r;
        r.scaling = scaling;
        r.last    = last;
        scale_pending = {scale_pending, r};
        items_queued = items_queued + 1;
    endtask

    // Mostly values near the round's base so that ties and restarts happen.
    function automatic logic [SCALE_W-1:0] pick_scaling(input logic [SCALE_W-1:0] base,
                                                         input int tol);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 65535);
            1:       v = base;
            2:       v = int'(base) - int'($urandom_range(0, (tol > 30000 ? 30000 : tol) + 2));
            default: v = int'(base) + int'($urandom_range(1, 3));
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SCALE_W-1:0];
    endfunction

    // Queues whole rounds until the item count reaches the target; a full
    // 64-process round can be put first, closed by its count or by tlast.
    task automatic queue_rounds(input int target, input int tol,
                                input bit long_round, input bit long_last);
        int count;
        int len;
        logic [SCALE_W-1:0] base;
        count = 0;
        if (long_round)
        begin
            base = $urandom_range(0, 65535);
            for (int i = 0; i < MAX_PROC; i++)
                push_item(pick_scaling(base, tol), long_last && i == MAX_PROC - 1);
            count = MAX_PROC;
        end
        while (count < target)
        begin
            len  = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 30)
                                                 : $urandom_range(1, 10);
            base = $urandom_range(0, 65535);
            for (int i = 0; i < len; i++)
                push_item(pick_scaling(base, tol), i == len - 1);
            count = count + len;
        end
    endtask

    // Waits until every queued request is taken and every grant has arrived.
    task automatic drain_block();
        while (items_accepted != items_queued)
            @(posedge clk);
        while (grants_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Request driver: holds a request until taken, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (scale_pending.size() > 0)
            begin
                drv_req = scale_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_req.scaling;
                s_tlast  <= drv_req.last;
                if (src_idle_on && $urandom_range(0, 4) == 0)
                    src_gap <= $urandom_range(1, 19);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: one long hold-off when armed, else random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            snk_gap   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            m_tready <= 1'b0;
            if (hold_left == HOLD_CYCLES)
                hold_done <= 1'b1;
            else
                hold_left <= hold_left + 1;
        end
        else if (snk_gap > 0)
        begin
            m_tready <= 1'b0;
            snk_gap  <= snk_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (snk_idle_on && $urandom_range(0, 5) == 0)
                snk_gap <= $urandom_range(1, 19);
        end
    end

    // Register writes and accepted requests update the shadow model.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOTAL_CORES: mdl_total = cfg_data[CORES_W-1:0];
                CFG_TIE_TOL:     mdl_tol   = cfg_data[TOL_W-1:0];
                default:         ;
            endcase
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_allocation(s_tdata[SCALE_W-1:0], s_tlast);
            items_accepted = items_accepted + 1;
        end
    end

    // Grant checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_grant.index = m_tdata[IDX_W-1:0];
            got_grant.cores = m_tdata[IDX_W +: CORES_W];
            got_grant.last  = m_tlast;
            if (grants_expected.size() == 0)
            begin
                $error("grant for process %0d with no grant expected", got_grant.index);
                fail_count = fail_count + 1;
            end
            else
            begin
                want_grant = grants_expected.pop_front();
                grants_checked = grants_checked + 1;
                if (got_grant.index !== want_grant.index)
                begin
                    $error("process_index: expected %0d, got %0d",
                           want_grant.index, got_grant.index);
                    fail_count = fail_count + 1;
                end
                if (got_grant.cores !== want_grant.cores)
                begin
                    $error("alloc_cores: expected %0d, got %0d",
                           want_grant.cores, got_grant.cores);
                    fail_count = fail_count + 1;
                end
                if (got_grant.last !== want_grant.last)
                begin
                    $error("last_alloc: expected %0d, got %0d",
                           want_grant.last, got_grant.last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL throughput_core_allocator");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: lone zero, lone all-ones, tie window edges, restart.
        push_item(16'h0000, 1'b1);
        push_item(16'hFFFF, 1'b1);
        push_item(16'h1000, 1'b0);
        push_item(16'h0FFE, 1'b0);
        push_item(16'h1000, 1'b0);
        push_item(16'h0FF0, 1'b0);
        push_item(16'h1001, 1'b0);
        push_item(16'h0FFD, 1'b1);
        push_item(16'h5555, 1'b0);
        push_item(16'hAAAA, 1'b1);
        drain_block();

        // Too few cores: one core against one non-best process; exact ties only.
        write_reg(CFG_TOTAL_CORES, 16'd1);
        write_reg(CFG_TIE_TOL, 16'd0);
        push_item(16'h2000, 1'b0);
        push_item(16'h1000, 1'b0);
        push_item(16'h2000, 1'b1);
        drain_block();

        // Zero cores.
        write_reg(CFG_TOTAL_CORES, 16'd0);
        write_reg(CFG_TIE_TOL, 16'd4);
        push_item(16'h0005, 1'b0);
        push_item(16'h0005, 1'b1);
        push_item(16'h0009, 1'b0);
        push_item(16'h0003, 1'b1);
        drain_block();

        // Largest budget, everything ties.
        write_reg(CFG_TOTAL_CORES, 16'd4096);
        write_reg(CFG_TIE_TOL, 16'hFFFF);
        queue_rounds(30, 65535, 1'b0, 1'b0);
        drain_block();

        // Smallest nonzero budget, exact ties only.
        write_reg(CFG_TOTAL_CORES, 16'd1);
        write_reg(CFG_TIE_TOL, 16'd0);
        queue_rounds(30, 0, 1'b0, 1'b0);
        drain_block();

        // Random settings with a round closed by its process count alone.
        write_reg(CFG_TOTAL_CORES, 16'($urandom_range(1, 4096)));
        write_reg(CFG_TIE_TOL, 16'($urandom_range(0, 64)));
        queue_rounds(90, 64, 1'b1, 1'b0);
        drain_block();

        // Long output stall while requests keep coming, so the input backs up.
        write_reg(CFG_TOTAL_CORES, 16'd16);
        write_reg(CFG_TIE_TOL, 16'd4);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        hold_armed  = 1'b1;
        queue_rounds(35, 4, 1'b0, 1'b0);
        drain_block();

        // Final stretch with no idling, full round closed by tlast.
        write_reg(CFG_TOTAL_CORES, 16'($urandom_range(1, 4096)));
        write_reg(CFG_TIE_TOL, 16'($urandom_range(0, 4096)));
        queue_rounds(90, 4096, 1'b1, 1'b1);
        drain_block();

        $display("Checked %0d core grants from %0d scaling requests in %0d rounds.",
                 grants_checked, items_accepted, rounds_closed);
        $display("Budgets ran from 0 to 4096 cores, tie windows from 0 to 65535.");
        if (fail_count == 0)
            $display("PASS throughput_core_allocator");
        else
            $display("FAIL throughput_core_allocator");
        $finish;
    end

endmodule

`default_nettype wire

// ===== throughput_core_allocator.f =====
+incdir+hw/rtl
hw/rtl/thr_pkg.sv
hw/rtl/thr_front.sv
hw/rtl/thr_queue.sv
hw/rtl/thr_div.sv
hw/rtl/thr_back.sv
hw/rtl/throughput_core_allocator.sv
sim/throughput_core_allocator_tb.sv
